### hdl/safk_pkg.sv
package safk_pkg;

	// Sequencer steps of one link
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_DELIVER = 5'd17;

	// Multiplier operand A select
	localparam logic [1:0] ASEL_COS = 2'd0;
	localparam logic [1:0] ASEL_SIN = 2'd1;
	localparam logic [1:0] ASEL_LEN = 2'd2;

	// Writeback destination
	localparam logic [1:0] DST_P   = 2'd0;
	localparam logic [1:0] DST_Z   = 2'd1;
	localparam logic [1:0] DST_POS = 2'd2;

	// Frame axes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam int COORD_W   = 24;
	localparam int COORD_MAX = 8388607;
	localparam int COORD_MIN = -8388608;

	typedef struct packed {
		logic issue;
		logic clr;
		logic neg;
	} mac_ctrl_t;

	typedef struct packed {
		mac_ctrl_t  mac;
		logic [1:0] asel;
		logic       use_z;
		logic [1:0] comp;
	} uop_t;

	typedef struct packed {
		logic       en;
		logic [1:0] dst;
		logic [1:0] comp;
	} wb_t;

	// Issue pattern: per component P*c, -Z*s (new P), P*s, Z*c (new Z);
	// then length times each new Z component.
	function automatic uop_t uop_of(logic [STEP_W-1:0] step);
		uop_t u;
		logic [STEP_W-1:0] t;
		u = '0;
		t = step - STEP_W'(12);
		if (step < STEP_W'(12)) begin
			u.comp = step[3:2];
			case (step[1:0])
				2'd0: begin
					u.mac.issue = 1'b1;
					u.mac.clr   = 1'b1;
					u.asel      = ASEL_COS;
				end
				2'd1: begin
					u.mac.issue = 1'b1;
					u.mac.neg   = 1'b1;
					u.asel      = ASEL_SIN;
					u.use_z     = 1'b1;
				end
				2'd2: begin
					u.mac.issue = 1'b1;
					u.mac.clr   = 1'b1;
					u.asel      = ASEL_SIN;
				end
				2'd3: begin
					u.mac.issue = 1'b1;
					u.asel      = ASEL_COS;
					u.use_z     = 1'b1;
				end
				default: u = '0;
			endcase
		end else if (step < STEP_W'(15)) begin
			u.mac.issue = 1'b1;
			u.mac.clr   = 1'b1;
			u.asel      = ASEL_LEN;
			u.use_z     = 1'b1;
			u.comp      = t[1:0];
		end
		return u;
	endfunction

	// Accumulator result lands once the closing issue has passed the product and accumulator registers
	function automatic wb_t wb_of(logic [STEP_W-1:0] step);
		wb_t w;
		logic [STEP_W-1:0] t;
		logic [STEP_W-1:0] p;
		w = '0;
		t = step - STEP_W'(3);
		p = step - STEP_W'(14);
		if (step >= STEP_W'(3) && step <= STEP_W'(13) && !t[0]) begin
			w.en   = 1'b1;
			w.comp = t[3:2];
			w.dst  = t[1] ? DST_Z : DST_P;
		end else if (step >= STEP_W'(14) && step <= STEP_W'(16)) begin
			w.en   = 1'b1;
			w.dst  = DST_POS;
			w.comp = p[1:0];
		end
		return w;
	endfunction

	// (a * b) >> 60, kept to 64 bits
	function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// sin(k degrees) in Q.frac, Taylor series at 60 fraction bits, rounded
	function automatic logic [31:0] sin_entry(int k, int frac);
		logic [63:0] deg;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		deg  = 64'h3243F6A8885A308D / 64'd180;
		x    = deg * 64'(k);
		x2   = mul_q60(x, x);
		term = x;
		sum  = x;
		term = mul_q60(term, x2) / 64'd6;   sum = sum - term;
		term = mul_q60(term, x2) / 64'd20;  sum = sum + term;
		term = mul_q60(term, x2) / 64'd42;  sum = sum - term;
		term = mul_q60(term, x2) / 64'd72;  sum = sum + term;
		term = mul_q60(term, x2) / 64'd110; sum = sum - term;
		term = mul_q60(term, x2) / 64'd156; sum = sum + term;
		term = mul_q60(term, x2) / 64'd210; sum = sum - term;
		term = mul_q60(term, x2) / 64'd272; sum = sum + term;
		term = mul_q60(term, x2) / 64'd342; sum = sum - term;
		term = mul_q60(term, x2) / 64'd420; sum = sum + term;
		term = mul_q60(term, x2) / 64'd506; sum = sum - term;
		term = mul_q60(term, x2) / 64'd600; sum = sum + term;
		r = (sum + (64'd1 << (59 - frac))) >> (60 - frac);
		return r[31:0];
	endfunction

endpackage

### hdl/serial_arm_forward_kinematics_top.sv
// Forward kinematics of a serial arm, one link per request. Each request
// carries a link length (unsigned Q8.8) and the servo angle at its near end
// in whole degrees (saturated to -90..90); tlast marks the hand link. The
// block turns its orientation frame (Q2.FRAME_FRAC_BITS) about its own Y axis
// on odd links and its own X axis on even links, then returns the link's far
// end in Q15.8 with 24-bit saturation, a sticky below-ground flag on tuser and
// the hand marker on tlast. After the hand link, or the link that reaches
// MAX_LINKS, the arm state returns to the origin and the identity frame.
// A link occupies the block from its taken request until its result is
// loaded: fifteen products go one per cycle through the single shared
// multiply-accumulate unit (twelve for the frame turn, three for length
// times the new Z axis), its pipeline drains, and the output register loads.
// A new link is accepted only once the last one is loaded; the output
// register lets the next link be accepted while a result still waits.
module serial_arm_forward_kinematics_top #(
	parameter int MAX_LINKS       = 64,
	parameter int FRAME_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // link_length[15:0], servo_angle[23:16]
	input  logic        s_axis_tlast,   // last_link
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // end_x[23:0], end_y[47:24], end_z[71:48]
	output logic [0:0]  m_axis_tuser,   // below_ground[0]
	output logic        m_axis_tlast    // is_hand
);

	localparam int FW    = FRAME_FRAC_BITS + 2;
	localparam int AW    = (FW > 17) ? FW : 17;
	localparam int PW    = AW + FW;
	localparam int SW    = PW + 2;
	localparam int CNT_W = $clog2(MAX_LINKS + 1);
	localparam int CW    = safk_pkg::COORD_W;

	localparam logic signed [FW-1:0] FRAME_ONE = FW'(1) <<< FRAME_FRAC_BITS;
	localparam logic signed [SW-1:0] ONE_SW    = SW'(1);
	localparam logic signed [SW-1:0] FMAX      = (ONE_SW <<< (FRAME_FRAC_BITS + 1)) - ONE_SW;
	localparam logic signed [SW-1:0] FMIN      = -(ONE_SW <<< (FRAME_FRAC_BITS + 1));
	localparam logic signed [SW-1:0] CMAX      = SW'(safk_pkg::COORD_MAX);
	localparam logic signed [SW-1:0] CMIN      = SW'(safk_pkg::COORD_MIN);

	// sequencer and arm state
	logic                            busy_q;
	logic [safk_pkg::STEP_W-1:0]     step_q;
	logic [15:0]                     len_q;
	logic                            last_q;
	logic                            odd_q;
	logic                            ground_q;
	logic [CNT_W-1:0]                cnt_q;
	logic signed [FW-1:0]            fr_q [0:8];
	logic signed [CW-1:0]            pos_q [0:2];

	// output register
	logic                            out_vld_q;
	logic [71:0]                     out_data_q;
	logic                            out_user_q;
	logic                            out_last_q;

	logic                            in_take;
	logic                            out_load;
	logic                            hand;
	logic [CNT_W:0]                  cnt_nx;
	safk_pkg::uop_t                  uop;
	safk_pkg::wb_t                   wb;
	safk_pkg::mac_ctrl_t             mac_ctrl;
	logic [1:0]                      b_axis;
	logic [3:0]                      b_idx;
	logic [1:0]                      w_axis;
	logic [3:0]                      w_idx;
	logic signed [FW-1:0]            sin_q;
	logic signed [FW-1:0]            cos_q;
	logic signed [AW-1:0]            op_a;
	logic signed [FW-1:0]            op_b;
	logic signed [PW:0]              acc;
	logic signed [PW:0]              rnd;
	logic signed [SW-1:0]            rnd_x;
	logic signed [SW-1:0]            fr_sat;
	logic signed [SW-1:0]            pos_sum;
	logic signed [SW-1:0]            pos_sat;
	logic signed [FW-1:0]            fr_new;
	logic signed [CW-1:0]            pos_new;

	assign s_axis_tready = !busy_q;
	assign in_take       = s_axis_tvalid && !busy_q;
	assign out_load      = busy_q && (step_q == safk_pkg::STEP_DELIVER) &&
		(!out_vld_q || m_axis_tready);

	// sine and cosine of the clamped angle, sine negated on even links so
	// both turn axes share one update pattern
	safk_sin_rom #(
		.FRAC  (FRAME_FRAC_BITS)
	) u_rom (
		.clk   (clk),
		.ld    (in_take),
		.angle ($signed(s_axis_tdata[23:16])),
		.flip  (!odd_q),
		.sin_q (sin_q),
		.cos_q (cos_q)
	);

	always_comb begin
		uop            = safk_pkg::uop_of(step_q);
		wb             = safk_pkg::wb_of(step_q);
		mac_ctrl       = uop.mac;
		mac_ctrl.issue = uop.mac.issue && busy_q;

		// turned axis P: X on odd links, Y on even links
		b_axis = uop.use_z ? safk_pkg::AXIS_Z : (odd_q ? safk_pkg::AXIS_X : safk_pkg::AXIS_Y);
		b_idx  = {2'b00, b_axis} * 4'd3 + {2'b00, uop.comp};
		w_axis = (wb.dst == safk_pkg::DST_Z) ? safk_pkg::AXIS_Z :
			(odd_q ? safk_pkg::AXIS_X : safk_pkg::AXIS_Y);
		w_idx  = {2'b00, w_axis} * 4'd3 + {2'b00, wb.comp};

		case (uop.asel)
			safk_pkg::ASEL_COS: op_a = AW'(cos_q);
			safk_pkg::ASEL_SIN: op_a = AW'(sin_q);
			safk_pkg::ASEL_LEN: op_a = AW'($signed({1'b0, len_q}));
			default:            op_a = '0;
		endcase
		op_b = fr_q[b_idx];
	end

	safk_mac #(
		.AW   (AW),
		.BW   (FW),
		.FRAC (FRAME_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (op_a),
		.b      (op_b),
		.acc    (acc)
	);

	// round, saturate to the frame range or add to the joint coordinate
	always_comb begin
		rnd     = acc >>> FRAME_FRAC_BITS;
		rnd_x   = SW'(rnd);
		if (rnd_x > FMAX) begin
			fr_sat = FMAX;
		end else if (rnd_x < FMIN) begin
			fr_sat = FMIN;
		end else begin
			fr_sat = rnd_x;
		end
		fr_new  = fr_sat[FW-1:0];
		pos_sum = SW'(pos_q[wb.comp]) + rnd_x;
		if (pos_sum > CMAX) begin
			pos_sat = CMAX;
		end else if (pos_sum < CMIN) begin
			pos_sat = CMIN;
		end else begin
			pos_sat = pos_sum;
		end
		pos_new = pos_sat[CW-1:0];
		cnt_nx  = {1'b0, cnt_q} + {{CNT_W{1'b0}}, 1'b1};
		hand    = last_q || (cnt_nx >= (CNT_W+1)'(MAX_LINKS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= '0;
			last_q   <= 1'b0;
			odd_q    <= 1'b1;
			ground_q <= 1'b0;
			cnt_q    <= '0;
			for (int i = 0; i < 9; i++) begin
				fr_q[i] <= (i % 4 == 0) ? FRAME_ONE : '0;
			end
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
			end
		end else begin
			if (in_take) begin
				busy_q <= 1'b1;
				step_q <= '0;
				last_q <= s_axis_tlast;
			end else if (busy_q && step_q != safk_pkg::STEP_DELIVER) begin
				step_q <= step_q + safk_pkg::STEP_W'(1);
			end

			// write back the finished accumulation
			if (busy_q && wb.en) begin
				if (wb.dst == safk_pkg::DST_POS) begin
					pos_q[wb.comp] <= pos_new;
					if (wb.comp == 2'd2 && pos_new[CW-1]) begin
						ground_q <= 1'b1;
					end
				end else begin
					fr_q[w_idx] <= fr_new;
				end
			end

			// deliver: drop back to the origin after the hand link
			if (out_load) begin
				busy_q <= 1'b0;
				if (hand) begin
					odd_q    <= 1'b1;
					ground_q <= 1'b0;
					cnt_q    <= '0;
					for (int i = 0; i < 9; i++) begin
						fr_q[i] <= (i % 4 == 0) ? FRAME_ONE : '0;
					end
					for (int i = 0; i < 3; i++) begin
						pos_q[i] <= '0;
					end
				end else begin
					odd_q <= !odd_q;
					cnt_q <= cnt_nx[CNT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			len_q <= s_axis_tdata[15:0];
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {pos_q[2], pos_q[1], pos_q[0]};
			out_user_q <= ground_q;
			out_last_q <= hand;
		end
	end

	assign m_axis_tvalid   = out_vld_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_user_q;
	assign m_axis_tlast    = out_last_q;

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> busy_q && step_q == '0)
		else $error("request taken but sequencer not started");

	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && step_q != safk_pkg::STEP_DELIVER
		|=> busy_q && step_q == $past(step_q) + safk_pkg::STEP_W'(1))
		else $error("sequencer failed to advance");

	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> !busy_q && m_axis_tvalid)
		else $error("result not loaded at end of link");

	a_no_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !mac_ctrl.issue)
		else $error("multiplier issued while idle");

endmodule

### hdl/safk_sin_rom.sv
module safk_sin_rom #(
	parameter int FRAC = 16
) (
	input  logic                   clk,
	input  logic                   ld,
	input  logic signed [7:0]      angle,
	input  logic                   flip,
	output logic signed [FRAC+1:0] sin_q,
	output logic signed [FRAC+1:0] cos_q
);

	logic [FRAC:0]          tab [0:90];
	logic signed [7:0]      ang_c;
	logic [7:0]             mag8;
	logic [6:0]             mag;
	logic [6:0]             cidx;
	logic signed [FRAC+1:0] sin_v;
	logic signed [FRAC+1:0] cos_v;

	for (genvar k = 0; k <= 90; k++) begin : g_tab
		localparam logic [31:0] V = safk_pkg::sin_entry(k, FRAC);
		assign tab[k] = V[FRAC:0];
	end

	always_comb begin
		// saturate the servo angle to the quarter turn
		if (angle > 8'sd90) begin
			ang_c = 8'sd90;
		end else if (angle < -8'sd90) begin
			ang_c = -8'sd90;
		end else begin
			ang_c = angle;
		end
		mag8  = ang_c[7] ? 8'(-ang_c) : 8'(ang_c);
		mag   = mag8[6:0];
		cidx  = 7'd90 - mag;
		sin_v = $signed({1'b0, tab[mag]});
		cos_v = $signed({1'b0, tab[cidx]});
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			sin_q <= (ang_c[7] ^ flip) ? -sin_v : sin_v;
			cos_q <= cos_v;
		end
	end

endmodule

### hdl/safk_mac.sv
module safk_mac #(
	parameter int AW   = 18,
	parameter int BW   = 18,
	parameter int FRAC = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  safk_pkg::mac_ctrl_t     ctrl,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW:0]   acc
);

	// clear loads half an LSB of the result so a plain shift rounds
	localparam logic signed [AW+BW:0] HALF = (AW+BW+1)'(1) <<< (FRAC - 1);

	safk_pkg::mac_ctrl_t      ctrl_s1;
	logic signed [AW+BW-1:0]  prod_s1;
	logic signed [AW+BW:0]    acc_q;
	logic signed [AW+BW:0]    base;
	logic signed [AW+BW:0]    prod_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_comb begin
		base   = ctrl_s1.clr ? HALF : acc_q;
		prod_x = (AW+BW+1)'(prod_s1);
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.issue) begin
			acc_q <= ctrl_s1.neg ? base - prod_x : base + prod_x;
		end
	end

	assign acc = acc_q;

endmodule
